// ----- rtl/csvrfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV row field encoder package
// Item codes, status codes, output byte selection and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package csvrfe_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN_ROW = 2'd0,
		OP_FIELD_BYTE = 2'd1,
		OP_END_FIELD = 2'd2,
		OP_END_ROW = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PHASE_ERR = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SEL_NONE = 3'd0,
		SEL_COMMA = 3'd1,
		SEL_QUOTE = 3'd2,
		SEL_NEWLINE = 3'd3,
		SEL_DATA = 3'd4
	} sel_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;

	typedef struct packed {
		logic store_byte;
		logic clear_field;
		logic rd_start;
		logic rd_next;
		logic emit;
		sel_t emit_sel;
		logic emit_last;
		status_t emit_status;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic in_byte_zero;
		logic buf_full;
		logic buf_empty;
		logic quoting;
		logic rd_at_last;
		logic rd_is_quote;
		logic rd_printable;
	} stat_t;

endpackage

// ----- rtl/csvrfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV row field encoder datapath
// Field buffer, fill count, quoting flag, read pointer and output register.
// ----------------------------------------------------------------------------
module csvrfe_dp #(
	parameter int FIELD_BYTES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csvrfe_pkg::cmd_t     cmd,
	output csvrfe_pkg::stat_t    st,
	input  logic [7:0]           in_byte,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [7:0]           m_byte,
	output logic                 m_byte_valid,
	output logic                 m_last,
	output csvrfe_pkg::status_t  m_status
);

	localparam int LW = $clog2(FIELD_BYTES + 1);
	localparam int AW = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;

	logic [7:0]    store_q [FIELD_BYTES];
	logic [LW-1:0] length_q;
	logic [LW-1:0] rd_q;
	logic          quoting_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          byte_valid_q;
	logic          last_q;
	csvrfe_pkg::status_t status_q;

	logic [7:0] rd_byte;
	logic [7:0] emit_byte;
	logic       out_free;

	assign rd_byte = store_q[rd_q[AW-1:0]];
	assign out_free = !valid_q || m_ready;

	always_comb begin
		st.out_free = out_free;
		st.in_byte_zero = (in_byte == 8'd0);
		st.buf_full = (length_q == LW'(FIELD_BYTES));
		st.buf_empty = (length_q == '0);
		st.quoting = quoting_q;
		st.rd_at_last = ((rd_q + LW'(1)) == length_q);
		st.rd_is_quote = (rd_byte == csvrfe_pkg::CH_QUOTE);
		st.rd_printable = (rd_byte >= csvrfe_pkg::CH_PRINT_LO) &&
			(rd_byte <= csvrfe_pkg::CH_PRINT_HI);
	end

	always_comb begin
		unique case (cmd.emit_sel)
			csvrfe_pkg::SEL_COMMA:   emit_byte = csvrfe_pkg::CH_COMMA;
			csvrfe_pkg::SEL_QUOTE:   emit_byte = csvrfe_pkg::CH_QUOTE;
			csvrfe_pkg::SEL_NEWLINE: emit_byte = csvrfe_pkg::CH_NEWLINE;
			csvrfe_pkg::SEL_DATA:    emit_byte = rd_byte;
			default:                 emit_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.store_byte) begin
			store_q[length_q[AW-1:0]] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			quoting_q <= 1'b0;
			rd_q <= '0;
		end else begin
			if (cmd.clear_field) begin
				length_q <= '0;
				quoting_q <= 1'b0;
			end else if (cmd.store_byte) begin
				length_q <= length_q + LW'(1);
				if (in_byte == csvrfe_pkg::CH_QUOTE || in_byte == csvrfe_pkg::CH_COMMA) begin
					quoting_q <= 1'b1;
				end
			end
			if (cmd.rd_start) begin
				rd_q <= '0;
			end else if (cmd.rd_next) begin
				rd_q <= rd_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= emit_byte;
			byte_valid_q <= (cmd.emit_sel != csvrfe_pkg::SEL_NONE);
			last_q <= cmd.emit_last;
			status_q <= cmd.emit_status;
		end
	end

	assign m_valid = valid_q;
	assign m_byte = byte_q;
	assign m_byte_valid = byte_valid_q;
	assign m_last = last_q;
	assign m_status = status_q;

endmodule

// ----- rtl/csvrfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV row field encoder controller
// Row phase, field counter, fields-per-row register and the field drain
// sequencer.
// ----------------------------------------------------------------------------
module csvrfe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  csvrfe_pkg::op_t    in_op,
	output logic               in_ready,
	input  csvrfe_pkg::stat_t  st,
	output csvrfe_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_COMMA,
		S_OPENQ,
		S_BODY,
		S_DQ,
		S_CLOSEQ
	} state_t;

	typedef enum logic [1:0] {
		PH_BEGIN,
		PH_FIELD,
		PH_END
	} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [7:0] index_q, index_d;
	logic [7:0] fpr_q;
	logic [7:0] index_inc;

	assign in_ready = (state_q == S_IDLE) && st.out_free;
	assign index_inc = index_q + 8'd1;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		phase_d = phase_q;
		index_d = index_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_sel = csvrfe_pkg::SEL_NONE;
					cmd.emit_status = csvrfe_pkg::ST_OK;
					unique case (in_op)
						csvrfe_pkg::OP_BEGIN_ROW: begin
							if (phase_q != PH_BEGIN) begin
								cmd.emit_status = csvrfe_pkg::ST_PHASE_ERR;
							end else begin
								phase_d = PH_FIELD;
								index_d = 8'd0;
								cmd.clear_field = 1'b1;
							end
						end
						csvrfe_pkg::OP_FIELD_BYTE: begin
							if (phase_q != PH_FIELD) begin
								cmd.emit_status = csvrfe_pkg::ST_PHASE_ERR;
							end else if (st.in_byte_zero) begin
								cmd.emit_status = csvrfe_pkg::ST_OK;
							end else if (st.buf_full) begin
								cmd.emit_status = csvrfe_pkg::ST_OVERFLOW;
							end else begin
								cmd.store_byte = 1'b1;
							end
						end
						csvrfe_pkg::OP_END_FIELD: begin
							if (phase_q != PH_FIELD) begin
								cmd.emit_status = csvrfe_pkg::ST_PHASE_ERR;
							end else begin
								index_d = index_inc;
								if (index_inc >= fpr_q) begin
									phase_d = PH_END;
								end
								cmd.rd_start = 1'b1;
								// The bytes of the field leave in the drain states.
								if (index_q != 8'd0) begin
									cmd.emit = 1'b0;
									state_d = S_COMMA;
								end else if (st.quoting) begin
									cmd.emit = 1'b0;
									state_d = S_OPENQ;
								end else if (!st.buf_empty) begin
									cmd.emit = 1'b0;
									state_d = S_BODY;
								end else begin
									cmd.clear_field = 1'b1;
								end
							end
						end
						csvrfe_pkg::OP_END_ROW: begin
							if (phase_q != PH_END) begin
								cmd.emit_status = csvrfe_pkg::ST_PHASE_ERR;
							end else begin
								phase_d = PH_BEGIN;
								cmd.emit_sel = csvrfe_pkg::SEL_NEWLINE;
							end
						end
						default: begin
							cmd.emit_status = csvrfe_pkg::ST_PHASE_ERR;
						end
					endcase
				end
			end
			S_COMMA: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = csvrfe_pkg::SEL_COMMA;
					cmd.emit_last = !st.quoting && st.buf_empty;
					if (st.quoting) begin
						state_d = S_OPENQ;
					end else if (st.buf_empty) begin
						cmd.clear_field = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_BODY;
					end
				end
			end
			S_OPENQ: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = csvrfe_pkg::SEL_QUOTE;
					state_d = st.buf_empty ? S_CLOSEQ : S_BODY;
				end
			end
			S_BODY: begin
				if (!st.quoting) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_sel = csvrfe_pkg::SEL_DATA;
						cmd.emit_last = st.rd_at_last;
						cmd.rd_next = 1'b1;
						if (st.rd_at_last) begin
							cmd.clear_field = 1'b1;
							state_d = S_IDLE;
						end
					end
				end else if (!st.rd_printable) begin
					// Bytes below 0x20 or above 0x7F are dropped inside a quoted field.
					cmd.rd_next = 1'b1;
					if (st.rd_at_last) begin
						state_d = S_CLOSEQ;
					end
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.rd_is_quote) begin
						cmd.emit_sel = csvrfe_pkg::SEL_QUOTE;
						state_d = S_DQ;
					end else begin
						cmd.emit_sel = csvrfe_pkg::SEL_DATA;
						cmd.rd_next = 1'b1;
						if (st.rd_at_last) begin
							state_d = S_CLOSEQ;
						end
					end
				end
			end
			S_DQ: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = csvrfe_pkg::SEL_DATA;
					cmd.rd_next = 1'b1;
					state_d = st.rd_at_last ? S_CLOSEQ : S_BODY;
				end
			end
			S_CLOSEQ: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = csvrfe_pkg::SEL_QUOTE;
					cmd.emit_last = 1'b1;
					cmd.clear_field = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_BEGIN;
			index_q <= 8'd0;
			fpr_q <= 8'd1;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			index_q <= index_d;
			if (cfg_we) begin
				fpr_q <= cfg_wdata;
			end
		end
	end

endmodule

// ----- rtl/csv_row_field_encoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV row field encoder
// Builds CSV rows from begin-row, field-byte, end-of-field and end-row beats.
// ----------------------------------------------------------------------------
// Input beats carry the operation in s_axis_tuser and a field byte in
// s_axis_tdata. Each output beat carries one result: m_axis_tdata is the
// CSV byte, m_axis_tuser holds byte_valid and status, and m_axis_tlast marks
// the final result of the input beat that caused it.
// Begin row, field byte, end row and rejected beats give one result beat,
// registered in the cycle after acceptance; the block then takes one input
// beat per cycle while the output is drained.
// After an end of field is accepted its bytes leave one per cycle while the
// output is drained: comma, quotes, doubled quotes and field-buffer bytes.
// A byte dropped from a quoted field still takes a drain step of its own.
// No input beat is taken while a field drains.
// A stalled receiver holds the output register; the drain and the input side
// simply wait. Reset puts the row phase to waiting for begin row, clears the
// field counter and buffer fill, and sets fields_per_row to 1.
// The user writes fields_per_row by cfg_we / cfg_wdata only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module csv_row_field_encoder_unit #(
	parameter int FIELD_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] field_byte
	input  logic [1:0] s_axis_tuser,  // [1:0] operation
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [2:0] m_axis_tuser,  // [0] byte_valid, [2:1] status
	output logic       m_axis_tlast
);

	csvrfe_pkg::cmd_t    cmd;
	csvrfe_pkg::stat_t   st;
	csvrfe_pkg::status_t out_status;
	logic                out_byte_valid;

	csvrfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_op     (csvrfe_pkg::op_t'(s_axis_tuser)),
		.in_ready  (s_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	csvrfe_dp #(
		.FIELD_BYTES (FIELD_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_byte      (s_axis_tdata),
		.m_valid      (m_axis_tvalid),
		.m_ready      (m_axis_tready),
		.m_byte       (m_axis_tdata),
		.m_byte_valid (out_byte_valid),
		.m_last       (m_axis_tlast),
		.m_status     (out_status)
	);

	assign m_axis_tuser = {out_status, out_byte_valid};

endmodule
